[hw/rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Request and register codes, field widths, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int SUM_W     = 35;
    localparam int POS_W     = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [1:0] REQ_WR_A    = 2'd0;
    localparam logic [1:0] REQ_WR_B    = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             mac_en;
        logic             mac_first;
        logic             mac_last;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] k_idx;
        logic             last_elem;
    } mme_cmd_t;

    typedef struct packed {
        logic out_taken;
    } mme_stat_t;

endpackage

[hw/rtl/mme_if.sv]
// ----------------------------------------------------------------------------
// mme_if: channel interfaces of the matrix multiply engine
// Request, configuration and result channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface mme_req_if import mme_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [POS_W-1:0]             row_index;
    logic [POS_W-1:0]             col_index;
    logic signed [ELEM_WIDTH-1:0] elem_value;

    modport source (output valid, output req_type, output row_index, output col_index,
                    output elem_value, input ready);
    modport sink (input valid, input req_type, input row_index, input col_index,
                  input elem_value, output ready);
endinterface

interface mme_cfg_if import mme_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface mme_rsp_if import mme_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [SUM_W-1:0] sum_value;
    logic                    last;

    modport source (output valid, output out_row, output out_col, output sum_value,
                    output last, input ready);
    modport sink (input valid, input out_row, input out_col, input sum_value,
                  input last, output ready);
endinterface

[hw/rtl/mme_ctrl.sv]
// ----------------------------------------------------------------------------
// mme_ctrl: controller of the matrix multiply engine
// Holds the size registers, decodes request items and steps the row, column
// and inner-dimension counters that drive the datapath.
// ----------------------------------------------------------------------------
module mme_ctrl import mme_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mme_req_if.sink    req,
    mme_cfg_if.sink    cfg,
    output mme_cmd_t   cmd,
    input  mme_stat_t  stat
);

    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAC  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [CW-1:0]    r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [DW-1:0]    nr, nk, nc;
    logic             req_acc, row_end, col_end, k_end, last_elem, wr_a_ok, wr_b_ok;

    function automatic logic [DW-1:0] dim_clamp(input logic [CFG_W-1:0] v);
        logic [DW-1:0] d;
        if (v == '0)
            d = DW'(1);
        else if (int'(v) > MAX_DIM)
            d = DW'(MAX_DIM);
        else
            d = DW'(v);
        return d;
    endfunction

    assign nr = dim_clamp(rows_a_reg);
    assign nk = dim_clamp(inner_dim_reg);
    assign nc = dim_clamp(cols_b_reg);

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_acc   = req.valid && req.ready;

    assign k_end     = (k_reg == CW'(nk - DW'(1)));
    assign row_end   = (r_reg == CW'(nr - DW'(1)));
    assign col_end   = (c_reg == CW'(nc - DW'(1)));
    assign last_elem = row_end && col_end;

    assign wr_a_ok = (int'(req.row_index) < int'(nr)) && (int'(req.col_index) < int'(nk));
    assign wr_b_ok = (int'(req.row_index) < int'(nk)) && (int'(req.col_index) < int'(nc));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_RESET;
            inner_dim_reg <= CFG_RESET;
            cols_b_reg    <= CFG_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_ROWS_A:    rows_a_reg    <= cfg.data;
                CFG_INNER_DIM: inner_dim_reg <= cfg.data;
                CFG_COLS_B:    cols_b_reg    <= cfg.data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && req.req_type == REQ_COMPUTE)
                begin
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                end
            end
            ST_WAIT:
            begin
                if (stat.out_taken)
                begin
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MAC;
                        if (col_end)
                        begin
                            c_next = '0;
                            r_next = r_reg + CW'(1);
                        end
                        else
                        begin
                            c_next = c_reg + CW'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        cmd.wr_a      = req_acc && (req.req_type == REQ_WR_A) && wr_a_ok;
        cmd.wr_b      = req_acc && (req.req_type == REQ_WR_B) && wr_b_ok;
        cmd.mac_en    = (state_reg == ST_MAC);
        cmd.mac_first = (k_reg == '0);
        cmd.mac_last  = k_end;
        cmd.row       = CNT_W'(r_reg);
        cmd.col       = CNT_W'(c_reg);
        cmd.k_idx     = CNT_W'(k_reg);
        cmd.last_elem = last_elem;
    end

`ifndef SYNTHESIS
    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.req_type == REQ_COMPUTE |=> state_reg == ST_MAC)
        else $error("compute item did not start the multiply loop");

    a_mac_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC && k_end |=> state_reg == ST_WAIT)
        else $error("inner loop did not end on its final step");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WAIT && stat.out_taken && last_elem |=> state_reg == ST_IDLE)
        else $error("controller kept running after the final element");
`endif

endmodule

[hw/rtl/mme_datapath.sv]
// ----------------------------------------------------------------------------
// mme_datapath: datapath of the matrix multiply engine
// Element stores for A and B, a registered read stage, one multiplier with a
// product register, the accumulator and the result output register.
// ----------------------------------------------------------------------------
module mme_datapath import mme_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mme_cmd_t                     cmd,
    output mme_stat_t                    stat,
    input  logic [POS_W-1:0]             wr_row,
    input  logic [POS_W-1:0]             wr_col,
    input  logic signed [ELEM_WIDTH-1:0] wr_value,
    mme_rsp_if.source                    rsp
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

    logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
    logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];

    logic [AW-1:0]                wr_addr, a_rd_addr, b_rd_addr;
    logic signed [ELEM_WIDTH-1:0] a_q_reg, b_q_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [EXT_W-1:0]      prod_ext;
    logic signed [SUM_W-1:0]      prod_sum, acc_reg, acc_next, out_sum_reg;
    logic                         v1_reg, first1_reg, last1_reg;
    logic                         v2_reg, first2_reg, last2_reg;
    logic                         out_valid_reg, out_last_reg;
    logic [POS_W-1:0]             out_row_reg, out_col_reg;

    assign wr_addr   = AW'(int'(wr_row) * MAX_DIM + int'(wr_col));
    assign a_rd_addr = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.k_idx));
    assign b_rd_addr = AW'(int'(cmd.k_idx) * MAX_DIM + int'(cmd.col));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            a_mem[wr_addr] <= wr_value;
        if (cmd.mac_en)
            a_q_reg <= a_mem[a_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
            b_mem[wr_addr] <= wr_value;
        if (cmd.mac_en)
            b_q_reg <= b_mem[b_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            prod_reg <= a_q_reg * b_q_reg;
    end

    assign prod_ext = EXT_W'(prod_reg);
    assign prod_sum = prod_ext[SUM_W-1:0];
    assign acc_next = first2_reg ? prod_sum : acc_reg + prod_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            first1_reg    <= 1'b0;
            last1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            first2_reg    <= 1'b0;
            last2_reg     <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= cmd.mac_en;
            first1_reg <= cmd.mac_first;
            last1_reg  <= cmd.mac_en && cmd.mac_last;
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            if (v2_reg)
                acc_reg <= acc_next;
            if (v2_reg && last2_reg)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && last2_reg)
        begin
            out_sum_reg  <= acc_next;
            out_row_reg  <= cmd.row[POS_W-1:0];
            out_col_reg  <= cmd.col[POS_W-1:0];
            out_last_reg <= cmd.last_elem;
        end
    end

    assign stat.out_taken = out_valid_reg && rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_row   = out_row_reg;
    assign rsp.out_col   = out_col_reg;
    assign rsp.sum_value = out_sum_reg;
    assign rsp.last      = out_last_reg;

`ifndef SYNTHESIS
    a_no_mac_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_en |-> !out_valid_reg)
        else $error("multiply started while a result was still pending");

    a_last_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && last2_reg |=> out_valid_reg)
        else $error("finished sum did not reach the output register");

    a_pipe_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_en && cmd.mac_last |-> ##2 last2_reg)
        else $error("final product lost in the multiply pipeline");
`endif

endmodule

[hw/rtl/matrix_multiply_engine.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_engine: dense signed integer matrix multiply
// Stores A and B element by element and streams out the product A * B.
// ----------------------------------------------------------------------------
// Channels: req carries items that write one element of A (req_type 0) or of
// B (req_type 1) at row_index, col_index, or start a compute (req_type 2).
// Writes outside the configured sizes are dropped. cfg writes rows_a,
// inner_dim and cols_b (index 0, 1, 2); write it only while the engine is
// idle. rsp returns one item per product element in row-major order, with
// last set on the final element.
// Timing: a compute occupies the engine until its final element is taken on
// rsp: one multiply-accumulate per cycle through a single multiplier, each
// product passing the read registers and the product register into the
// accumulator, then the finished sum waits in the output register to be handed
// over. req is not ready during a compute.
// Reset: sizes return to 8 by 8 by 8, the output register empties, element
// stores keep no defined contents until written.
// Stall: while rsp is not ready the pending element holds and the inner loop
// waits.
// ----------------------------------------------------------------------------
module matrix_multiply_engine import mme_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mme_req_if.sink    req,
    mme_cfg_if.sink    cfg,
    mme_rsp_if.source  rsp
);

    mme_cmd_t  cmd;
    mme_stat_t stat;

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

    mme_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .wr_row   (req.row_index),
        .wr_col   (req.col_index),
        .wr_value (req.elem_value),
        .rsp      (rsp)
    );

endmodule
